// File: sv/qnt_pkg.sv
// qnt_pkg: shared constants and types for the dynamic int8 quantizer.
// Used by every module of the block but qnt_fifo; depends on nothing.
`default_nettype none
package qnt_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int SAMPLE_BITS  = 16;

    // magnitude bits kept from the rounding divider, saturating above
    localparam int QUO_BITS = 10;

    localparam int SCALE     = 255;
    localparam int ZP_OFFSET = 128;
    localparam int Q_MIN     = -128;
    localparam int Q_MAX     = 127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZSTART,
        S_ZDIV,
        S_READ,
        S_LOAD,
        S_QDIV,
        S_OUT
    } t_bk_state;

endpackage
`default_nettype wire

// File: sv/qnt_fifo.sv
// qnt_fifo: two-entry queue carrying run descriptors from front to back.
// Depends on nothing but its width parameter.
`default_nettype none
module qnt_fifo #(
    parameter int W = 39
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic              o_full,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_data [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         c_push, c_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_data[r_rp];
    assign c_push  = i_push && !o_full;
    assign c_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) r_wp <= ~r_wp;
            if (c_pop)  r_rp <= ~r_rp;
            if (c_push && !c_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!c_push && c_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) r_data[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// File: sv/qnt_front.sv
// qnt_front: accepts samples, writes them to the store, tracks min/max and
// queues a run descriptor at the end of a run. Uses qnt_pkg.
`default_nettype none
module qnt_front #(
    parameter int MAXE = qnt_pkg::MAX_ELEMENTS,
    parameter int SB   = qnt_pkg::SAMPLE_BITS,
    localparam int AW  = (MAXE > 1) ? $clog2(MAXE) : 1,
    localparam int CW  = $clog2(MAXE + 1),
    localparam int DW  = CW + 2 * SB
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic signed [SB-1:0] i_sample,
    input  wire logic                 i_final_item,
    input  wire logic                 i_run_done,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output logic [DW-1:0]             o_desc,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [SB-1:0]             o_wr_data
);

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [SB-1:0] r_min, r_max, n_min, n_max;
    logic                 r_busy;
    logic                 c_acc, c_last;

    assign o_in_stall = r_busy || i_q_full;
    assign c_acc      = i_in_valid && !o_in_stall;
    assign n_cnt      = r_cnt + CW'(1);
    assign n_min      = (i_sample < r_min) ? i_sample : r_min;
    assign n_max      = (i_sample > r_max) ? i_sample : r_max;
    assign c_last     = i_final_item || (n_cnt == CW'(MAXE));

    assign o_wr_en   = c_acc;
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_sample;
    assign o_push    = c_acc && c_last;
    assign o_desc    = {n_cnt, n_min, n_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_min  <= SMAX;
            r_max  <= SMIN;
            r_busy <= 1'b0;
        end else begin
            if (c_acc) begin
                if (c_last) begin
                    r_cnt  <= '0;
                    r_min  <= SMAX;
                    r_max  <= SMIN;
                    r_busy <= 1'b1;
                end else begin
                    r_cnt <= n_cnt;
                    r_min <= n_min;
                    r_max <= n_max;
                end
            end
            if (i_run_done) r_busy <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: sv/qnt_div.sv
// qnt_div: bit-serial rounding divider, round(mag/den) half away from zero,
// quotient saturated to QUO_BITS. Uses qnt_pkg.
`default_nettype none
module qnt_div #(
    parameter int SB = qnt_pkg::SAMPLE_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [SB+7:0]   i_mag,
    input  wire logic [SB:0]     i_den,
    output logic                 o_done,
    output logic [qnt_pkg::QUO_BITS-1:0] o_quo
);

    localparam int QB = qnt_pkg::QUO_BITS;
    localparam int WW = SB + 12;
    localparam int SW = $clog2(QB + 1);

    logic [WW-1:0] r_rem, r_dsh;
    logic [QB-1:0] r_quo;
    logic [SW-1:0] r_step;
    logic          r_busy, r_ovf, r_done;
    logic          c_bit;

    assign c_bit  = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quo  = r_ovf ? {QB{1'b1}} : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start)                      r_busy <= 1'b1;
            else if (r_busy && r_step == '0)  r_busy <= 1'b0;
        end
    end

    // (2|n| + d) / (2d); first step is the overflow check against 2d << QB
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= WW'({i_mag, 1'b0}) + WW'(i_den);
            r_dsh  <= WW'(i_den) << (QB + 1);
            r_step <= SW'(QB);
            r_quo  <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            if (c_bit) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            if (r_step == SW'(QB)) r_ovf <= c_bit;
            else                   r_quo <= {r_quo[QB-2:0], c_bit};
            if (r_step != '0) r_step <= r_step - SW'(1);
        end
    end

endmodule
`default_nettype wire

// File: sv/qnt_back.sv
// qnt_back: holds the sample store, computes range and zero point for a run
// and emits the quantized samples. Uses qnt_pkg and qnt_div.
`default_nettype none
module qnt_back #(
    parameter int MAXE = qnt_pkg::MAX_ELEMENTS,
    parameter int SB   = qnt_pkg::SAMPLE_BITS,
    localparam int AW  = (MAXE > 1) ? $clog2(MAXE) : 1,
    localparam int CW  = $clog2(MAXE + 1),
    localparam int DW  = CW + 2 * SB
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_desc_valid,
    input  wire logic [DW-1:0] i_desc,
    output logic               o_pop,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [SB-1:0] i_wr_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic signed [7:0]  o_quant_value,
    output logic signed [7:0]  o_zero_offset,
    output logic [15:0]        o_value_range,
    output logic               o_range_error,
    output logic               o_end_of_run,
    output logic               o_run_done
);

    localparam int QB = qnt_pkg::QUO_BITS;
    localparam int RW = SB + 1;
    localparam int PW = SB + 9;
    localparam int VW = QB + 2;
    localparam logic signed [PW-1:0] K   = PW'(qnt_pkg::SCALE);
    localparam logic signed [VW-1:0] ZHI = VW'(qnt_pkg::SCALE);
    localparam logic signed [VW-1:0] ZOF = VW'(qnt_pkg::ZP_OFFSET);
    localparam logic signed [VW-1:0] QLO = VW'(qnt_pkg::Q_MIN);
    localparam logic signed [VW-1:0] QHI = VW'(qnt_pkg::Q_MAX);

    logic [SB-1:0] r_mem [MAXE];
    logic signed [SB-1:0] r_rdata;

    qnt_pkg::t_bk_state r_state, n_state;

    logic [CW-1:0]        r_n, r_idx;
    logic signed [SB-1:0] r_min;
    logic [RW-1:0]        r_range;
    logic                 r_err, r_neg, r_eor;
    logic signed [7:0]    r_zero, r_q;

    logic c_pop, c_zstart, c_qstart, c_zfin, c_qfin, c_qerr, c_fire, c_last;

    logic signed [SB-1:0] d_min, d_max, m_src;
    logic signed [PW-1:0] m_prod;
    logic [SB+7:0]        m_mag;
    logic                 div_done;
    logic [QB-1:0]        div_quo;
    logic signed [VW-1:0] sq, zc, v, vc;

    assign d_min = i_desc[2*SB-1:SB];
    assign d_max = i_desc[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    // zero point uses -min, so its sign is the inverse of the product sign
    assign m_src  = (r_state == qnt_pkg::S_ZSTART) ? r_min : r_rdata;
    assign m_prod = PW'(m_src) * K;
    assign m_mag  = m_prod[PW-1] ? (SB+8)'(-m_prod) : (SB+8)'(m_prod);

    qnt_div #(.SB(SB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_zstart || c_qstart),
        .i_mag   (m_mag),
        .i_den   (r_range),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign sq = r_neg ? -VW'({1'b0, div_quo}) : VW'({1'b0, div_quo});
    assign zc = (sq < 0) ? '0 : ((sq > ZHI) ? ZHI : sq);
    assign v  = sq + VW'(r_zero);
    assign vc = (v < QLO) ? QLO : ((v > QHI) ? QHI : v);
    assign c_last = (r_idx + CW'(1) == r_n);

    always_comb begin
        n_state = r_state;
        case (r_state)
            qnt_pkg::S_IDLE:   if (i_desc_valid) n_state = qnt_pkg::S_ZSTART;
            qnt_pkg::S_ZSTART: n_state = r_err ? qnt_pkg::S_READ : qnt_pkg::S_ZDIV;
            qnt_pkg::S_ZDIV:   if (div_done) n_state = qnt_pkg::S_READ;
            qnt_pkg::S_READ:   n_state = qnt_pkg::S_LOAD;
            qnt_pkg::S_LOAD:   n_state = r_err ? qnt_pkg::S_OUT : qnt_pkg::S_QDIV;
            qnt_pkg::S_QDIV:   if (div_done) n_state = qnt_pkg::S_OUT;
            qnt_pkg::S_OUT: begin
                if (!i_out_stall) n_state = c_last ? qnt_pkg::S_IDLE : qnt_pkg::S_READ;
            end
            default:           n_state = qnt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        c_pop    = 1'b0;
        c_zstart = 1'b0;
        c_qstart = 1'b0;
        c_zfin   = 1'b0;
        c_qfin   = 1'b0;
        c_qerr   = 1'b0;
        c_fire   = 1'b0;
        case (r_state)
            qnt_pkg::S_IDLE:   c_pop = i_desc_valid;
            qnt_pkg::S_ZSTART: c_zstart = !r_err;
            qnt_pkg::S_ZDIV:   c_zfin = div_done;
            qnt_pkg::S_LOAD: begin
                c_qstart = !r_err;
                c_qerr   = r_err;
            end
            qnt_pkg::S_QDIV:   c_qfin = div_done;
            qnt_pkg::S_OUT:    c_fire = !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= qnt_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (c_pop) begin
            r_n     <= i_desc[DW-1:2*SB];
            r_min   <= d_min;
            r_range <= RW'(d_max) - RW'(d_min);
            r_err   <= (d_max == d_min);
            r_zero  <= '0;
            r_idx   <= '0;
        end
        if (c_zstart) r_neg <= !m_prod[PW-1];
        if (c_qstart) r_neg <= m_prod[PW-1];
        if (c_zfin)   r_zero <= 8'(zc - ZOF);
        if (c_qfin || c_qerr) begin
            r_q   <= c_qerr ? 8'sd0 : 8'(vc);
            r_eor <= c_last;
        end
        if (c_fire && !c_last) r_idx <= r_idx + CW'(1);
    end

    assign o_pop         = c_pop;
    assign o_out_valid   = (r_state == qnt_pkg::S_OUT);
    assign o_quant_value = r_q;
    assign o_zero_offset = r_zero;
    assign o_value_range = 16'(r_range);
    assign o_range_error = r_err;
    assign o_end_of_run  = r_eor;
    assign o_run_done    = c_fire && c_last;

endmodule
`default_nettype wire

// File: sv/dynamic_int8_quantizer.sv
// Dynamic int8 quantizer: buffers up to MAX_ELEMENTS samples of a tensor,
// then emits each as int8 with the run's zero point and range. Input takes
// one sample per cycle while a run loads; after the last sample (or a full
// store) the input stalls until every result is delivered. The back end
// works out the zero point once per run, then handles one result at a time
// (store read, multiply, 11-step serial rounding divide, output register),
// reading the next sample only after the current result is taken. Top level;
// uses qnt_pkg, qnt_front, qnt_fifo and qnt_back.
`default_nettype none
module dynamic_int8_quantizer #(
    parameter int MAX_ELEMENTS = qnt_pkg::MAX_ELEMENTS,
    parameter int SAMPLE_BITS  = qnt_pkg::SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_final_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [7:0]                  o_quant_value,
    output logic signed [7:0]                  o_zero_offset,
    output logic [15:0]                        o_value_range,
    output logic                               o_range_error,
    output logic                               o_end_of_run
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int DW = CW + 2 * SAMPLE_BITS;

    logic                   push, pop, q_valid, q_full, run_done, wr_en;
    logic [DW-1:0]          desc_in, desc_out;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;

    qnt_front #(.MAXE(MAX_ELEMENTS), .SB(SAMPLE_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_final_item (i_final_item),
        .i_run_done   (run_done),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_desc       (desc_in),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    qnt_fifo #(.W(DW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (desc_out)
    );

    qnt_back #(.MAXE(MAX_ELEMENTS), .SB(SAMPLE_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc_valid  (q_valid),
        .i_desc        (desc_out),
        .o_pop         (pop),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_quant_value (o_quant_value),
        .o_zero_offset (o_zero_offset),
        .o_value_range (o_value_range),
        .o_range_error (o_range_error),
        .o_end_of_run  (o_end_of_run),
        .o_run_done    (run_done)
    );

endmodule
`default_nettype wire

// File: sim/dynamic_int8_quantizer_tb.sv
// Testbench for dynamic_int8_quantizer: directed table plus random tensors,
// each result checked against an in-bench quantizer predictor.
// Depends on qnt_pkg and the dynamic_int8_quantizer RTL.
`timescale 1ns / 1ps
module dynamic_int8_quantizer_tb;

    localparam int NUM_RANDOM  = 350;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic signed [7:0] quant;
        logic signed [7:0] zero;
        logic [15:0]       rng;
        logic              err;
        logic              last;
    } t_quant_result;

    typedef struct {
        logic signed [15:0] sample;
        logic               fin;
        logic               typed;       // expected results given in the row
        logic signed [7:0]  quant;
        logic signed [7:0]  zero;
        logic [15:0]        rng;
        logic               err;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_sample;
    logic               i_final_item;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [7:0]  o_quant_value;
    logic signed [7:0]  o_zero_offset;
    logic [15:0]        o_value_range;
    logic               o_range_error;
    logic               o_end_of_run;

    dynamic_int8_quantizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_sample(i_sample), .i_final_item(i_final_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_quant_value(o_quant_value), .o_zero_offset(o_zero_offset),
        .o_value_range(o_value_range), .o_range_error(o_range_error),
        .o_end_of_run(o_end_of_run)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] tensor_buf [qnt_pkg::MAX_ELEMENTS];
    int                 tensor_len;
    int                 tensor_min;
    int                 tensor_max;
    t_quant_result      pending_results [$];
    t_quant_result      typed_results [$];

    int  mismatches;
    int  results_seen;
    int  runs_done;
    int  error_runs;
    int  cycles;

    function automatic longint round_half_away(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (2 * mag + den) / (2 * den);
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void predict_quant(logic signed [15:0] x, logic fin);
        longint        rng;
        longint        zp;
        t_quant_result r;
        if (tensor_len >= qnt_pkg::MAX_ELEMENTS) tensor_len = 0;
        tensor_buf[tensor_len] = x;
        tensor_len++;
        if (x < tensor_min) tensor_min = x;
        if (x > tensor_max) tensor_max = x;
        if (!fin && tensor_len < qnt_pkg::MAX_ELEMENTS) return;
        rng = tensor_max - tensor_min;
        zp = 0;
        if (rng != 0)
            zp = clip(round_half_away(-longint'(tensor_min) * 255, rng), 0, 255) - 128;
        for (int k = 0; k < tensor_len; k++) begin
            r.quant = (rng == 0) ? 8'sd0 :
                8'(clip(round_half_away(longint'(tensor_buf[k]) * 255, rng) + zp,
                        qnt_pkg::Q_MIN, qnt_pkg::Q_MAX));
            r.zero = 8'(zp);
            r.rng  = 16'(rng);
            r.err  = (rng == 0);
            r.last = (k == tensor_len - 1);
            pending_results.push_back(r);
        end
        runs_done++;
        if (rng == 0) error_runs++;
        tensor_len = 0;
        tensor_min = 32767;
        tensor_max = -32768;
    endfunction

    // receiver: own stall pattern, checks every accepted transaction
    int stall_mode;
    always @(posedge i_clk) begin
        t_quant_result e;
        t_quant_result t;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result q=%0d at cycle %0d", o_quant_value, cycles);
                end else begin
                    e = pending_results.pop_front();
                    if (typed_results.size() != 0) begin
                        t = typed_results.pop_front();
                        if (t.quant !== e.quant || t.zero !== e.zero || t.rng !== e.rng ||
                            t.err !== e.err) begin
                            mismatches++;
                            if (mismatches <= MAX_SHOWN)
                                $display("table row disagrees with predictor: q %0d/%0d",
                                         t.quant, e.quant);
                        end
                    end
                    if (o_quant_value !== e.quant || o_zero_offset !== e.zero ||
                        o_value_range !== e.rng || o_range_error !== e.err ||
                        o_end_of_run !== e.last) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: exp q=%0d z=%0d r=%0d e=%b l=%b, ",
                                      "got q=%0d z=%0d r=%0d e=%b l=%b"},
                                     e.quant, e.zero, e.rng, e.err, e.last, o_quant_value,
                                     o_zero_offset, o_value_range, o_range_error, o_end_of_run);
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dynamic_int8_quantizer_tb: errors");
            $finish;
        end
    end

    // drive one transaction and hold it until accepted
    task automatic send_sample(logic signed [15:0] x, logic fin);
        i_in_valid   <= 1'b1;
        i_sample     <= x;
        i_final_item <= fin;
        predict_quant(x, fin);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            i_sample   <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    t_stim_row directed [$];

    function automatic t_stim_row row(int x, bit fin, bit typed = 0, int q = 0,
                                      int z = 0, int r = 0, bit er = 0);
        t_stim_row s;
        s.sample = 16'(x); s.fin = fin; s.typed = typed;
        s.quant = 8'(q); s.zero = 8'(z); s.rng = 16'(r); s.err = er;
        return s;
    endfunction

    function automatic logic signed [15:0] rand_sample(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 400)) - 16'sd200;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        int style;
        logic signed [15:0] base;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_sample = '0; i_final_item = 1'b0;
        i_out_stall = 1'b0;
        stall_mode = 0; cycles = 0; mismatches = 0; results_seen = 0;
        runs_done = 0; error_runs = 0;
        tensor_len = 0; tensor_min = 32767; tensor_max = -32768;

        // extremes: full span, equal samples (range error), single sample, then two spans of 255
        directed.push_back(row(-32768, 0, 1, -128, 0, 65535, 0));
        directed.push_back(row(32767, 1, 1, 127, 0, 65535, 0));
        directed.push_back(row(100, 0, 1, 0, 0, 0, 1));
        directed.push_back(row(100, 1, 1, 0, 0, 0, 1));
        directed.push_back(row(-5, 1, 1, 0, 0, 0, 1));
        directed.push_back(row(0, 0, 1, -128, -128, 255, 0));
        directed.push_back(row(255, 1, 1, 127, -128, 255, 0));
        directed.push_back(row(-255, 0, 1, -128, 127, 255, 0));
        directed.push_back(row(0, 1, 1, 127, 127, 255, 0));
        // half steps, then clamp of the quantized value
        directed.push_back(row(1, 0));
        directed.push_back(row(3, 0));
        directed.push_back(row(-3, 0));
        directed.push_back(row(7, 1));
        directed.push_back(row(-1000, 0));
        directed.push_back(row(12345, 0));
        directed.push_back(row(-32768, 1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // typed rows lead the table, so their results come first
        foreach (directed[i]) begin
            if (directed[i].typed) typed_results.push_back('{directed[i].quant,
                directed[i].zero, directed[i].rng, directed[i].err, 1'b0});
            send_sample(directed[i].sample, directed[i].fin);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        typed_results.delete();

        // a full store with no final mark closes the run itself
        for (int k = 0; k < qnt_pkg::MAX_ELEMENTS; k++) send_sample(16'($urandom), 1'b0);
        send_sample(16'sd42, 1'b1);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        sent = 0;
        while (sent < NUM_RANDOM) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, qnt_pkg::MAX_ELEMENTS)
                                               : $urandom_range(1, 8);
            style = $urandom_range(0, 4);
            base = 16'($urandom);
            for (int k = 0; k < len; k++) begin
                if (style == 4) send_sample(($urandom_range(0, 3) == 0) ? base : base + 16'sd1,
                                            k == len - 1);
                else if (style == 4 - 4 && $urandom_range(0, 9) == 0)
                    send_sample(base, k == len - 1);
                else send_sample(rand_sample(style), k == len - 1);
                sent++;
                sender_gap();
            end
            if ($urandom_range(0, 9) == 0) begin
                // constant tensor for the range error path
                send_sample(base, 1'b0);
                send_sample(base, 1'b1);
                sent += 2;
            end
            if ($urandom_range(0, 19) == 0) begin
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d tensors (%0d with zero range), %0d results checked",
                 runs_done, error_runs, results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("dynamic_int8_quantizer_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("dynamic_int8_quantizer_tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
sv/qnt_pkg.sv
sv/qnt_fifo.sv
sv/qnt_front.sv
sv/qnt_div.sv
sv/qnt_back.sv
sv/dynamic_int8_quantizer.sv
sim/dynamic_int8_quantizer_tb.sv
